### rtl/core/jsse_pkg.sv
// shared types, codes and constants of the job shop schedule evaluator
package jsse_pkg;

  // field and register widths
  localparam int TIME_W     = 24;
  localparam int PROC_W     = 16;
  localparam int COUNT_W    = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // default table dimensions
  localparam int DEF_MAX_JOBS     = 16;
  localparam int DEF_MAX_MACHINES = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_JOBS     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_MACHINES = 1'd1;

  // command codes
  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_SCHEDULE = 2'd1;
  localparam logic [1:0] CMD_VERIFY   = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_MACHINE  = 2'd1;
  localparam logic [1:0] ERR_JOB      = 2'd2;
  localparam logic [1:0] ERR_MAKESPAN = 2'd3;

  // request item
  typedef struct packed {
    logic [1:0]        command;
    logic [3:0]        job;
    logic [3:0]        machine;
    logic [PROC_W-1:0] proc_time;
  } req_item_t;

  // response item
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] makespan;
    logic              check_ok;
    logic [1:0]        error_kind;
  } rsp_item_t;

  // controller states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCHED,
    ST_CLEAR,
    ST_RD_A,
    ST_LAT_A,
    ST_RD_B,
    ST_CMP,
    ST_RESULT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic rd_from_port;
    logic latch_in;
    logic sweep_step;
    logic commit;
    logic load_out;
    logic v_start;
    logic v_lat_a;
    logic v_rd_b;
    logic v_cmp;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
    logic sweep_last;
    logic a_last;
    logic b_last;
    logic grp_last;
    logic pass_job;
  } dp_status_t;

endpackage

### rtl/core/jsse_ram.sv
// generic single write port ram with registered read
module jsse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/jsse_ctrl.sv
// sequencer for scheduling, clearing and verify walks
module jsse_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  input  logic [1:0]            req_command,
  output logic                  req_ready,
  output jsse_pkg::ctl_cmd_t    cmd,
  input  jsse_pkg::dp_status_t  status
);

  jsse_pkg::state_t state;
  jsse_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= jsse_pkg::ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      jsse_pkg::ST_INIT: begin
        if (status.sweep_last) state_next = jsse_pkg::ST_IDLE;
      end
      jsse_pkg::ST_IDLE: begin
        if (req_valid) begin
          case (req_command)
            jsse_pkg::CMD_CLEAR:    state_next = jsse_pkg::ST_CLEAR;
            jsse_pkg::CMD_SCHEDULE: state_next = jsse_pkg::ST_SCHED;
            jsse_pkg::CMD_VERIFY:   state_next = jsse_pkg::ST_RD_A;
            default:                state_next = jsse_pkg::ST_RESULT;
          endcase
        end
      end
      jsse_pkg::ST_SCHED: begin
        if (status.out_free) state_next = jsse_pkg::ST_IDLE;
      end
      jsse_pkg::ST_CLEAR: begin
        if (status.sweep_last) state_next = jsse_pkg::ST_RESULT;
      end
      jsse_pkg::ST_RD_A:  state_next = jsse_pkg::ST_LAT_A;
      jsse_pkg::ST_LAT_A: state_next = jsse_pkg::ST_RD_B;
      jsse_pkg::ST_RD_B:  state_next = jsse_pkg::ST_CMP;
      jsse_pkg::ST_CMP: begin
        if (!status.b_last) begin
          state_next = jsse_pkg::ST_RD_B;
        end else if (!status.a_last || !status.grp_last || !status.pass_job) begin
          state_next = jsse_pkg::ST_RD_A;
        end else begin
          state_next = jsse_pkg::ST_RESULT;
        end
      end
      jsse_pkg::ST_RESULT: begin
        if (status.out_free) state_next = jsse_pkg::ST_IDLE;
      end
      default: state_next = jsse_pkg::ST_INIT;
    endcase
  end

  // command outputs
  always_comb begin
    cmd       = '0;
    req_ready = 1'b0;
    case (state)
      jsse_pkg::ST_INIT: begin
        cmd.sweep_step = 1'b1;
      end
      jsse_pkg::ST_IDLE: begin
        req_ready        = 1'b1;
        cmd.rd_from_port = 1'b1;
        cmd.latch_in     = req_valid;
        cmd.v_start      = req_valid;
      end
      jsse_pkg::ST_SCHED: begin
        cmd.commit   = status.out_free;
        cmd.load_out = status.out_free;
      end
      jsse_pkg::ST_CLEAR: begin
        cmd.sweep_step = 1'b1;
      end
      jsse_pkg::ST_LAT_A: begin
        cmd.v_lat_a = 1'b1;
      end
      jsse_pkg::ST_RD_B: begin
        cmd.v_rd_b = 1'b1;
      end
      jsse_pkg::ST_CMP: begin
        cmd.v_cmp = 1'b1;
      end
      jsse_pkg::ST_RESULT: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### rtl/core/jsse_dp.sv
// datapath: ready tables, schedule tables, verify walk and response register
module jsse_dp #(
  parameter int MAX_JOBS     = jsse_pkg::DEF_MAX_JOBS,
  parameter int MAX_MACHINES = jsse_pkg::DEF_MAX_MACHINES
) (
  input  logic                              clk,
  input  logic                              rst,
  input  jsse_pkg::req_item_t               req,
  input  logic                              cfg_we,
  input  logic [jsse_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jsse_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  jsse_pkg::ctl_cmd_t                cmd,
  output jsse_pkg::dp_status_t              status,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output jsse_pkg::rsp_item_t               rsp
);

  localparam int TDEPTH  = MAX_JOBS * MAX_MACHINES;
  localparam int TAW     = (TDEPTH > 1) ? $clog2(TDEPTH) : 1;
  localparam int JAW     = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int MAW     = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;
  localparam int TW      = jsse_pkg::TIME_W;
  localparam int PW      = jsse_pkg::PROC_W;
  localparam int CW      = jsse_pkg::COUNT_W;
  localparam int ENTRY_W = TW + PW;

  // saturating finish time
  function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] t, input logic [PW-1:0] p);
    logic [TW:0] s;
    s = {1'b0, t} + {{(TW - PW + 1){1'b0}}, p};
    return s[TW] ? jsse_pkg::TIME_MAX : s[TW-1:0];
  endfunction

  // two operations share no time on their resource
  function automatic logic disjoint(input logic [TW-1:0] sa, input logic [PW-1:0] pa,
                                    input logic [TW-1:0] sb, input logic [PW-1:0] pb);
    logic [TW:0] ea;
    logic [TW:0] eb;
    ea = {1'b0, sa} + {{(TW - PW + 1){1'b0}}, pa};
    eb = {1'b0, sb} + {{(TW - PW + 1){1'b0}}, pb};
    return ({1'b0, sb} >= ea) || ({1'b0, sa} >= eb);
  endfunction

  // table address of a job and machine pair
  function automatic logic [TAW-1:0] tbl_addr(input logic [CW-1:0] j, input logic [CW-1:0] m);
    return TAW'(32'(j) * MAX_MACHINES + 32'(m));
  endfunction

  // configuration registers
  logic [CW-1:0] num_jobs;
  logic [CW-1:0] num_machines;
  logic [CW-1:0] nj;
  logic [CW-1:0] nm;

  // item and running state
  jsse_pkg::req_item_t item;
  logic [TW-1:0]       running;
  logic [TAW-1:0]      sweep;

  // verify walk state
  logic          pass_job;
  logic [CW-1:0] grp;
  logic [CW-1:0] a_ix;
  logic [CW-1:0] b_ix;
  logic [TW-1:0] a_start;
  logic [PW-1:0] a_proc;
  logic [TW-1:0] sel_start;
  logic [PW-1:0] sel_proc;
  logic [TW-1:0] best;
  logic          mach_err;
  logic          job_err;

  // memory ports
  logic               mr_we;
  logic [MAW-1:0]     mr_waddr;
  logic [MAW-1:0]     mr_raddr;
  logic [TW-1:0]      mr_q;
  logic               jr_we;
  logic [JAW-1:0]     jr_waddr;
  logic [JAW-1:0]     jr_raddr;
  logic [TW-1:0]      jr_q;
  logic               tb_we;
  logic [TAW-1:0]     tb_waddr;
  logic [ENTRY_W-1:0] tb_wdata;
  logic [TAW-1:0]     tb_raddr;
  logic [ENTRY_W-1:0] tb_q;
  logic [TW-1:0]      ready_wdata;

  // combinational values
  logic          in_range;
  logic [TW-1:0] op_start;
  logic [TW-1:0] op_finish;
  logic [TW-1:0] b_start;
  logic [PW-1:0] b_proc;
  logic [TW-1:0] sel_finish;
  logic [CW-1:0] lim_ab;
  logic [CW-1:0] lim_grp;
  logic [TAW-1:0] addr_a;
  logic [TAW-1:0] addr_b;
  logic          sweep_last;
  logic          a_last;
  logic          b_last;
  logic          grp_last;
  logic          out_free;
  logic [1:0]    v_err;
  jsse_pkg::rsp_item_t rsp_next;

  // effective counts: zero taken as one, others clamped to the table size
  always_comb begin
    if (num_jobs == '0) begin
      nj = CW'(1);
    end else if (32'(num_jobs) > MAX_JOBS) begin
      nj = CW'(MAX_JOBS);
    end else begin
      nj = num_jobs;
    end
    if (num_machines == '0) begin
      nm = CW'(1);
    end else if (32'(num_machines) > MAX_MACHINES) begin
      nm = CW'(MAX_MACHINES);
    end else begin
      nm = num_machines;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      num_jobs     <= CW'(1);
      num_machines <= CW'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        jsse_pkg::REG_NUM_JOBS:     num_jobs     <= cfg_data;
        jsse_pkg::REG_NUM_MACHINES: num_machines <= cfg_data;
        default: ;
      endcase
    end
  end

  // item latch
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      item <= req;
    end
  end

  // schedule arithmetic
  always_comb begin
    in_range  = ({1'b0, item.job} < nj) && ({1'b0, item.machine} < nm);
    op_start  = (mr_q > jr_q) ? mr_q : jr_q;
    op_finish = sat_add(op_start, item.proc_time);
  end

  // clearing sweep and running makespan
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep   <= '0;
      running <= '0;
    end else if (cmd.sweep_step) begin
      sweep   <= sweep_last ? '0 : sweep + TAW'(1);
      running <= '0;
    end else if (cmd.commit && in_range && op_finish > running) begin
      running <= op_finish;
    end
  end

  assign sweep_last = (32'(sweep) == TDEPTH - 1);

  // ready table ports
  always_comb begin
    ready_wdata = cmd.sweep_step ? '0 : op_finish;
    mr_we    = (cmd.sweep_step && 32'(sweep) < MAX_MACHINES) || (cmd.commit && in_range);
    jr_we    = (cmd.sweep_step && 32'(sweep) < MAX_JOBS) || (cmd.commit && in_range);
    mr_waddr = cmd.sweep_step ? MAW'(sweep) : MAW'(item.machine);
    jr_waddr = cmd.sweep_step ? JAW'(sweep) : JAW'(item.job);
    mr_raddr = cmd.rd_from_port ? MAW'(req.machine) : MAW'(item.machine);
    jr_raddr = cmd.rd_from_port ? JAW'(req.job) : JAW'(item.job);
  end

  // schedule table ports
  always_comb begin
    lim_ab   = pass_job ? nm : nj;
    lim_grp  = pass_job ? nj : nm;
    addr_a   = pass_job ? tbl_addr(grp, a_ix) : tbl_addr(a_ix, grp);
    addr_b   = pass_job ? tbl_addr(grp, b_ix) : tbl_addr(b_ix, grp);
    tb_we    = cmd.sweep_step || (cmd.commit && in_range);
    tb_waddr = cmd.sweep_step ? sweep : tbl_addr({1'b0, item.job}, {1'b0, item.machine});
    tb_wdata = cmd.sweep_step ? '0 : {op_start, item.proc_time};
    tb_raddr = cmd.v_rd_b ? addr_b : addr_a;
  end

  jsse_ram #(.WIDTH(TW), .DEPTH(MAX_MACHINES)) u_machine_ready (
    .clk   (clk),
    .we    (mr_we),
    .waddr (mr_waddr),
    .wdata (ready_wdata),
    .raddr (mr_raddr),
    .rdata (mr_q)
  );

  jsse_ram #(.WIDTH(TW), .DEPTH(MAX_JOBS)) u_job_ready (
    .clk   (clk),
    .we    (jr_we),
    .waddr (jr_waddr),
    .wdata (ready_wdata),
    .raddr (jr_raddr),
    .rdata (jr_q)
  );

  jsse_ram #(.WIDTH(ENTRY_W), .DEPTH(TDEPTH)) u_sched_table (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wdata (tb_wdata),
    .raddr (tb_raddr),
    .rdata (tb_q)
  );

  // verify walk decode
  always_comb begin
    b_start    = tb_q[ENTRY_W-1:PW];
    b_proc     = tb_q[PW-1:0];
    a_last     = (a_ix == lim_ab - CW'(1));
    b_last     = (b_ix == lim_ab - CW'(1));
    grp_last   = (grp == lim_grp - CW'(1));
    sel_finish = sat_add(sel_start, sel_proc);
  end

  // verify walk: machine pass then job pass
  always_ff @(posedge clk) begin
    if (rst) begin
      pass_job <= 1'b0;
      grp      <= '0;
      a_ix     <= '0;
      b_ix     <= '0;
      mach_err <= 1'b0;
      job_err  <= 1'b0;
      best     <= '0;
    end else if (cmd.v_start) begin
      pass_job <= 1'b0;
      grp      <= '0;
      a_ix     <= '0;
      b_ix     <= '0;
      mach_err <= 1'b0;
      job_err  <= 1'b0;
      best     <= '0;
    end else if (cmd.v_cmp) begin
      // pairwise overlap of the held operation and the one just read
      if (b_ix != a_ix && !disjoint(a_start, a_proc, b_start, b_proc)) begin
        if (pass_job) begin
          job_err <= 1'b1;
        end else begin
          mach_err <= 1'b1;
        end
      end
      if (!b_last) begin
        b_ix <= b_ix + CW'(1);
      end else begin
        b_ix <= '0;
        if (!a_last) begin
          a_ix <= a_ix + CW'(1);
        end else begin
          a_ix <= '0;
          // machine done: fold its latest-starting operation into the makespan
          if (!pass_job && sel_finish > best) begin
            best <= sel_finish;
          end
          if (!grp_last) begin
            grp <= grp + CW'(1);
          end else begin
            grp      <= '0;
            pass_job <= ~pass_job;
          end
        end
      end
    end
  end

  // held operation and latest start on the current machine
  always_ff @(posedge clk) begin
    if (cmd.v_lat_a) begin
      a_start <= b_start;
      a_proc  <= b_proc;
      if (!pass_job && (a_ix == '0 || b_start >= sel_start)) begin
        sel_start <= b_start;
        sel_proc  <= b_proc;
      end
    end
  end

  // response assembly
  always_comb begin
    if (mach_err) begin
      v_err = jsse_pkg::ERR_MACHINE;
    end else if (job_err) begin
      v_err = jsse_pkg::ERR_JOB;
    end else if (best != running) begin
      v_err = jsse_pkg::ERR_MAKESPAN;
    end else begin
      v_err = jsse_pkg::ERR_NONE;
    end
    rsp_next             = '0;
    rsp_next.makespan    = running;
    rsp_next.check_ok    = 1'b1;
    rsp_next.error_kind  = jsse_pkg::ERR_NONE;
    case (item.command)
      jsse_pkg::CMD_SCHEDULE: begin
        if (in_range) begin
          rsp_next.start_time  = op_start;
          rsp_next.finish_time = op_finish;
          rsp_next.makespan    = (op_finish > running) ? op_finish : running;
        end
      end
      jsse_pkg::CMD_VERIFY: begin
        rsp_next.makespan   = best;
        rsp_next.error_kind = v_err;
        rsp_next.check_ok   = (v_err == jsse_pkg::ERR_NONE);
      end
      default: begin
        rsp_next.makespan = running;
      end
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.load_out) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp <= rsp_next;
    end
  end

  assign out_free = !rsp_valid || rsp_ready;

  // status to the controller
  always_comb begin
    status.out_free   = out_free;
    status.sweep_last = sweep_last;
    status.a_last     = a_last;
    status.b_last     = b_last;
    status.grp_last   = grp_last;
    status.pass_job   = pass_job;
  end

endmodule

### rtl/core/job_shop_schedule_evaluator_core.sv
// top level of the job shop schedule evaluator
//
// Request items on req (valid/ready) carry a command, job, machine and
// processing time; each one gives exactly one response item on rsp.
// num_jobs and num_machines are set through the cfg write port; the user
// must write them only while idle, which the block does not enforce.
// Schedule: the machine and job ready times are read as the item is
// accepted, then committed once the output register is free, and the
// response is registered. The read-modify-write of the ready-time
// memories ends before a new item is taken.
// Clear: sweeps the schedule table and ready times, one entry per cycle,
// over all MAX_JOBS*MAX_MACHINES table entries.
// Verify: walks every pair through the single table read port, first
// for machine overlap, then for job overlap. The makespan is recomputed
// in the first walk.
// Reset: configuration returns to one job and one machine and the tables
// are cleared by a sweep over all MAX_JOBS*MAX_MACHINES table entries;
// req_ready stays low until it ends.
// A stalled receiver holds the response in its output register; the next
// request is still taken and waits only when its own response is due.
module job_shop_schedule_evaluator_core #(
  parameter int MAX_JOBS     = jsse_pkg::DEF_MAX_JOBS,
  parameter int MAX_MACHINES = jsse_pkg::DEF_MAX_MACHINES
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  jsse_pkg::req_item_t              req,
  output logic                             rsp_valid,
  input  logic                             rsp_ready,
  output jsse_pkg::rsp_item_t              rsp,
  input  logic                             cfg_we,
  input  logic [jsse_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [jsse_pkg::CFG_DATA_W-1:0]  cfg_data
);

  jsse_pkg::ctl_cmd_t   cmd;
  jsse_pkg::dp_status_t status;

  // sequencer
  jsse_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_command (req.command),
    .req_ready   (req_ready),
    .cmd         (cmd),
    .status      (status)
  );

  // datapath
  jsse_dp #(
    .MAX_JOBS     (MAX_JOBS),
    .MAX_MACHINES (MAX_MACHINES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // one item in flight: an accepted item closes the request side
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while an item is in progress");

  // clearing sweep runs right after reset
  a_sweep_after_reset: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !req_ready)
    else $error("request taken before the table sweep");

  // pass flag agrees with the error code
  a_ok_matches_error: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.check_ok == (rsp.error_kind == jsse_pkg::ERR_NONE)))
    else $error("check_ok disagrees with error_kind");

  // finish never precedes start and never exceeds the makespan
  a_time_order: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.finish_time >= rsp.start_time) && (rsp.makespan >= rsp.finish_time))
    else $error("response times out of order");

endmodule

### tb/job_shop_schedule_checker.sv
// checker: predicts and compares the response items of the job shop schedule evaluator
module job_shop_schedule_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  input  logic                            req_ready,
  input  jsse_pkg::req_item_t             req,
  input  logic                            rsp_valid,
  input  logic                            rsp_ready,
  input  jsse_pkg::rsp_item_t             rsp,
  input  logic                            cfg_we,
  input  logic [jsse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [jsse_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);
  import jsse_pkg::*;

  localparam int JOBS_CAP   = DEF_MAX_JOBS;
  localparam int MACHS_CAP  = DEF_MAX_MACHINES;

  // shadow of the block's registers and tables
  logic [COUNT_W-1:0] jobs_reg;
  logic [COUNT_W-1:0] machs_reg;
  logic [TIME_W-1:0]  mach_free_at [MACHS_CAP];
  logic [TIME_W-1:0]  job_free_at [JOBS_CAP];
  logic [TIME_W-1:0]  op_start [JOBS_CAP][MACHS_CAP];
  logic [PROC_W-1:0]  op_len [JOBS_CAP][MACHS_CAP];
  logic [TIME_W-1:0]  span_so_far;

  // responses still owed by the block, oldest first
  rsp_item_t awaited_rsp [$];

  function automatic int clamp_count(input logic [COUNT_W-1:0] v, input int cap);
    if (v == '0) return 1;
    if (int'(v) > cap) return cap;
    return int'(v);
  endfunction

  function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                input logic [PROC_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {{(TIME_W - PROC_W + 1){1'b0}}, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

  // two intervals do not overlap, judged on signed start difference
  function automatic bit apart(input logic [TIME_W-1:0] sa, input logic [PROC_W-1:0] pa,
                               input logic [TIME_W-1:0] sb, input logic [PROC_W-1:0] pb);
    int d;
    d = int'(sb) - int'(sa);
    return (d >= int'(pa)) || (-d >= int'(pb));
  endfunction

  function automatic void clear_tables();
    for (int m = 0; m < MACHS_CAP; m++) mach_free_at[m] = '0;
    for (int j = 0; j < JOBS_CAP; j++) begin
      job_free_at[j] = '0;
      for (int m = 0; m < MACHS_CAP; m++) begin
        op_start[j][m] = '0;
        op_len[j][m]   = '0;
      end
    end
    span_so_far = '0;
  endfunction

  // overlap checks in priority order, then makespan rebuilt from the tables
  function automatic void audit_schedule(output logic [TIME_W-1:0] rebuilt,
                                         output logic [1:0] fault);
    int nj;
    int nm;
    int i;
    int j;
    int k;
    int l;
    int sel;
    logic [TIME_W-1:0] fin;
    nj = clamp_count(jobs_reg, JOBS_CAP);
    nm = clamp_count(machs_reg, MACHS_CAP);
    fault = ERR_NONE;
    rebuilt = '0;
    // two jobs on one machine at once
    for (k = 0; k < nm && fault == ERR_NONE; k++)
      for (i = 0; i < nj && fault == ERR_NONE; i++)
        for (j = 0; j < nj && fault == ERR_NONE; j++)
          if (j != i && !apart(op_start[i][k], op_len[i][k], op_start[j][k], op_len[j][k]))
            fault = ERR_MACHINE;
    // one job on two machines at once
    for (k = 0; k < nm && fault == ERR_NONE; k++)
      for (l = 0; l < nm && fault == ERR_NONE; l++)
        for (i = 0; i < nj && fault == ERR_NONE; i++)
          if (k != l && !apart(op_start[i][l], op_len[i][l], op_start[i][k], op_len[i][k]))
            fault = ERR_JOB;
    // latest start per machine, ties to the higher job
    for (k = 0; k < nm; k++) begin
      sel = 0;
      for (i = 1; i < nj; i++)
        if (op_start[i][k] >= op_start[sel][k]) sel = i;
      fin = add_sat(op_start[sel][k], op_len[sel][k]);
      if (fin > rebuilt) rebuilt = fin;
    end
    if (fault == ERR_NONE && rebuilt != span_so_far) fault = ERR_MAKESPAN;
  endfunction

  // apply one request item to the shadow state and form its response
  function automatic rsp_item_t schedule_response(input req_item_t it);
    rsp_item_t r;
    logic [TIME_W-1:0] begin_at;
    logic [TIME_W-1:0] rebuilt;
    logic [1:0] fault;
    r = '0;
    r.check_ok = 1'b1;
    r.error_kind = ERR_NONE;
    case (it.command)
      CMD_CLEAR: begin
        clear_tables();
      end
      CMD_SCHEDULE: begin
        if (int'(it.job) < clamp_count(jobs_reg, JOBS_CAP) &&
            int'(it.machine) < clamp_count(machs_reg, MACHS_CAP)) begin
          begin_at = (mach_free_at[it.machine] > job_free_at[it.job]) ?
                     mach_free_at[it.machine] : job_free_at[it.job];
          r.start_time = begin_at;
          r.finish_time = add_sat(begin_at, it.proc_time);
          op_start[it.job][it.machine] = begin_at;
          op_len[it.job][it.machine] = it.proc_time;
          mach_free_at[it.machine] = r.finish_time;
          job_free_at[it.job] = r.finish_time;
          if (r.finish_time > span_so_far) span_so_far = r.finish_time;
        end
      end
      default: ;
    endcase
    r.makespan = span_so_far;
    if (it.command == CMD_VERIFY) begin
      audit_schedule(rebuilt, fault);
      r.makespan = rebuilt;
      r.check_ok = (fault == ERR_NONE);
      r.error_kind = fault;
    end
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [TIME_W-1:0] want,
                               input logic [TIME_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
    end
  endtask

  // track register writes, accepted requests and accepted responses
  always @(posedge clk) begin
    rsp_item_t want;
    if (rst) begin
      jobs_reg = COUNT_W'(1);
      machs_reg = COUNT_W'(1);
      clear_tables();
      awaited_rsp.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NUM_JOBS) jobs_reg = cfg_data;
        else if (cfg_index == REG_NUM_MACHINES) machs_reg = cfg_data;
      end
      if (req_valid && req_ready)
        awaited_rsp.insert(awaited_rsp.size(), schedule_response(req));
      if (rsp_valid && rsp_ready) begin
        if (awaited_rsp.size() == 0) begin
          mismatches++;
          $display("%0t response item with none outstanding: expected nothing, got %h",
                   $time, rsp);
        end else begin
          want = awaited_rsp.pop_front();
          compare_field("start_time", want.start_time, rsp.start_time);
          compare_field("finish_time", want.finish_time, rsp.finish_time);
          compare_field("makespan", want.makespan, rsp.makespan);
          compare_field("check_ok", TIME_W'(want.check_ok), TIME_W'(rsp.check_ok));
          compare_field("error_kind", TIME_W'(want.error_kind), TIME_W'(rsp.error_kind));
        end
      end
    end
    outstanding = awaited_rsp.size();
  end

endmodule

### tb/job_shop_schedule_evaluator_core_tb.sv
// testbench top: stimulus, pacing and verdict for the job shop schedule evaluator
module job_shop_schedule_evaluator_core_tb;
  import jsse_pkg::*;

  localparam int WATCHDOG_LIMIT = 100000;
  localparam int ITEM_TARGET    = 1500;
  localparam int CHAIN_LEN      = 270;
  localparam int HOLD_CYCLES    = 300;
  localparam int HEAVY_PCT      = 81;
  localparam int LIGHT_PCT      = 10;
  localparam int LEN_MAX        = 2**PROC_W - 1;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum int {PACE_FULL, PACE_SEND_GAPS, PACE_RECV_STALLS, PACE_BOTH} pace_t;

  logic                  clk;
  logic                  rst;
  logic                  req_valid;
  logic                  req_ready;
  req_item_t             req;
  logic                  rsp_valid;
  logic                  rsp_ready;
  rsp_item_t             rsp;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int outstanding;

  // pacing and run statistics
  int send_gap_pct;
  int recv_stall_pct;
  int hold_requests;
  int eff_jobs;
  int eff_machs;
  int items_sent;
  int verifies_sent;
  int clears_sent;
  int settings_used;

  job_shop_schedule_evaluator_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  job_shop_schedule_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // response side: random stalls plus requested long hold-offs
  initial begin
    int hold_left;
    int holds_served;
    rsp_ready = 1'b0;
    hold_left = 0;
    holds_served = 0;
    forever begin
      @(negedge clk);
      if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: ends the run when no item moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t watchdog: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  function automatic int effective(input int raw, input int cap);
    if (raw == 0) return 1;
    return (raw > cap) ? cap : raw;
  endfunction

  // mostly short jobs, some zero length, some full range
  function automatic int pick_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 0;
    if (roll < 65) return $urandom_range(1, 50);
    if (roll < 85) return $urandom_range(51, 2000);
    return $urandom_range(0, LEN_MAX);
  endfunction

  // mostly small instances, sometimes large or out of range
  function automatic int pick_count();
    int roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(1, 6);
    if (roll < 85) return $urandom_range(7, 16);
    if (roll < 95) return $urandom_range(17, 31);
    return 0;
  endfunction

  // offer one item; returns at the edge where it is taken
  task automatic issue(input logic [1:0] cmd, input int job, input int mach, input int len);
    req_item_t it;
    it.command = cmd;
    it.job = job[3:0];
    it.machine = mach[3:0];
    it.proc_time = len[PROC_W-1:0];
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= it;
    do @(posedge clk); while (!req_ready);
    items_sent++;
    if (cmd == CMD_VERIFY) verifies_sent++;
    if (cmd == CMD_CLEAR) clears_sent++;
  endtask

  // command with don't-care fields filled at random
  task automatic issue_cmd(input logic [1:0] cmd);
    issue(cmd, $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, LEN_MAX));
  endtask

  task automatic drain(input int settle);
    @(negedge clk);
    req_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (settle) @(negedge clk);
  endtask

  // write both counts while idle and switch the pacing
  task automatic configure(input int jobs_raw, input int machs_raw, input pace_t pace,
                           input bit hold_off);
    drain(4);
    @(posedge clk);
    send_gap_pct = (pace == PACE_SEND_GAPS) ? HEAVY_PCT : (pace == PACE_BOTH) ? LIGHT_PCT : 0;
    recv_stall_pct = (pace == PACE_RECV_STALLS) ? HEAVY_PCT :
                     (pace == PACE_BOTH) ? LIGHT_PCT : 0;
    if (hold_off) hold_requests++;
    eff_jobs = effective(jobs_raw, DEF_MAX_JOBS);
    eff_machs = effective(machs_raw, DEF_MAX_MACHINES);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_NUM_JOBS;
    cfg_data <= jobs_raw[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_index <= REG_NUM_MACHINES;
    cfg_data <= machs_raw[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // long chain of near-maximum jobs that drives the times into saturation
  task automatic run_chain(input int jobs_used, input int machs_used);
    issue_cmd(CMD_CLEAR);
    repeat (CHAIN_LEN)
      issue(CMD_SCHEDULE, $urandom_range(0, jobs_used - 1), $urandom_range(0, machs_used - 1),
            LEN_MAX - $urandom_range(0, 255));
    issue_cmd(CMD_VERIFY);
  endtask

  // one schedule: clear, operations, verify, with some noise mixed in
  task automatic run_episode();
    int ops;
    int roll;
    int shift;
    if ($urandom_range(99) < 10) begin
      issue_cmd(CMD_VERIFY);
      return;
    end
    if ($urandom_range(99) < 85) issue_cmd(CMD_CLEAR);
    if (eff_jobs * eff_machs <= 40 && $urandom_range(1) == 1) begin
      // complete instance: every job visits every machine once
      shift = $urandom_range(0, eff_machs - 1);
      for (int r = 0; r < eff_machs; r++)
        for (int j = 0; j < eff_jobs; j++)
          issue(CMD_SCHEDULE, j, (j + r + shift) % eff_machs, pick_len());
    end else begin
      ops = $urandom_range(1, 24);
      repeat (ops) begin
        roll = $urandom_range(99);
        if (roll < 4)
          issue(CMD_SCHEDULE, $urandom_range(0, 15), $urandom_range(0, 15), pick_len());
        else if (roll < 6) issue_cmd(CMD_UNUSED);
        else if (roll < 8) issue_cmd(CMD_VERIFY);
        else if (roll < 9) issue_cmd(CMD_CLEAR);
        else
          issue(CMD_SCHEDULE, $urandom_range(0, eff_jobs - 1),
                $urandom_range(0, eff_machs - 1), pick_len());
      end
    end
    if ($urandom_range(99) < 90) issue_cmd(CMD_VERIFY);
  endtask

  // stimulus and verdict
  initial begin
    int jobs_raw;
    int machs_raw;
    int phase_no;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    send_gap_pct = 0;
    recv_stall_pct = 0;
    hold_requests = 0;
    eff_jobs = 1;
    eff_machs = 1;
    items_sent = 0;
    verifies_sent = 0;
    clears_sent = 0;
    settings_used = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // reset counts: one job, one machine
    issue(CMD_SCHEDULE, 0, 0, LEN_MAX);
    issue(CMD_SCHEDULE, 1, 0, 5);
    issue_cmd(CMD_VERIFY);

    // small instance, out of range indexes, unused command, overwrite
    configure(4, 3, PACE_FULL, 1'b0);
    issue_cmd(CMD_CLEAR);
    issue(CMD_SCHEDULE, 0, 0, 10);
    issue(CMD_SCHEDULE, 1, 0, 0);
    issue(CMD_SCHEDULE, 1, 1, 7);
    issue(CMD_SCHEDULE, 0, 1, LEN_MAX);
    issue(CMD_SCHEDULE, 3, 2, 20);
    issue(CMD_SCHEDULE, 2, 2, 0);
    issue(CMD_SCHEDULE, 15, 0, 1);
    issue(CMD_SCHEDULE, 0, 15, 1);
    issue(CMD_SCHEDULE, 4, 0, 3);
    issue_cmd(CMD_UNUSED);
    issue(CMD_SCHEDULE, 0, 0, 10);
    issue_cmd(CMD_VERIFY);

    // equal starts tie to the higher job, so the rebuilt makespan falls short
    issue_cmd(CMD_CLEAR);
    issue(CMD_SCHEDULE, 1, 0, 0);
    issue(CMD_SCHEDULE, 0, 0, 9);
    issue_cmd(CMD_VERIFY);
    issue_cmd(CMD_CLEAR);
    issue_cmd(CMD_VERIFY);

    // saturation: machine overlap, then job overlap
    configure(2, 1, PACE_SEND_GAPS, 1'b0);
    run_chain(2, 1);
    configure(1, 2, PACE_RECV_STALLS, 1'b0);
    run_chain(1, 2);

    // count extremes, clamped above and below
    configure(31, 16, PACE_BOTH, 1'b0);
    run_episode();
    configure(0, 0, PACE_FULL, 1'b0);
    run_episode();
    run_episode();

    // random settings and schedules
    phase_no = 0;
    while (items_sent < ITEM_TARGET) begin
      jobs_raw = pick_count();
      machs_raw = pick_count();
      if (effective(jobs_raw, DEF_MAX_JOBS) > 8 && effective(machs_raw, DEF_MAX_MACHINES) > 8)
        machs_raw = $urandom_range(1, 4);
      configure(jobs_raw, machs_raw, pace_t'(phase_no % 4), phase_no == 2);
      repeat ($urandom_range(2, 5)) run_episode();
      phase_no++;
    end

    drain(40);
    $display("ran %0d request items (%0d verifies, %0d clears) over %0d count settings,",
             items_sent, verifies_sent, clears_sent, settings_used);
    $display("with saturated chains, clamped counts and %0d long response hold-off",
             hold_requests);
    if (mismatches == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
